// ----- hdl/bez_pkg.sv -----
package bez_pkg;

    localparam int DEF_TABLE_SIZE   = 64;
    localparam int DEF_NEWTON_STEPS = 8;
    localparam int DEF_BISECT_STEPS = 20;

    localparam int CTRL_W  = 7;
    localparam int VAL_W   = 17;
    localparam int T_W     = 17;
    localparam int COEF_W  = 11;
    localparam int MAC_A_W = 48;
    localparam int MAC_B_W = 18;
    localparam int ACC_W   = 64;
    localparam int QUO_W   = 24;
    localparam int CNT_W   = 5;

    localparam int ONE_Q16       = 65536;
    localparam int TOL_Q32       = 429497;
    localparam int SLOPE_MIN_Q32 = 4295;
    localparam int SCALE         = 127;
    localparam int NEWTON_BITS   = 16;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOOP,
        ST_X1,
        ST_X2,
        ST_X3,
        ST_XE,
        ST_CHK,
        ST_S1,
        ST_S2,
        ST_S3,
        ST_DS,
        ST_DIV,
        ST_UPD,
        ST_Y1,
        ST_Y2,
        ST_Y3,
        ST_YR,
        ST_YQ,
        ST_YC,
        ST_YSAT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                      en;
        logic signed [MAC_A_W-1:0] a;
        logic signed [MAC_B_W-1:0] b;
        logic signed [ACC_W-1:0]   c;
    } t_mac_op;

endpackage

// ----- hdl/bez_mac.sv -----
module bez_mac
    import bez_pkg::*;
(
    input  logic                    i_clk,
    input  t_mac_op                 i_op,
    output logic signed [ACC_W-1:0] o_acc
);

    logic signed [MAC_A_W+MAC_B_W-1:0] w_prod;
    logic signed [ACC_W-1:0]           r_acc;

    assign w_prod = i_op.a * i_op.b;

    always_ff @(posedge i_clk) begin
        if (i_op.en) begin
            r_acc <= $signed(w_prod[ACC_W-1:0]) + i_op.c;
        end
    end

    assign o_acc = r_acc;

endmodule

// ----- hdl/bezier_easing_table_entry.sv -----
// channel   dir  tdata (low bit up)                                    tuser
// s_axis    in   ctrl_x1[6:0] ctrl_y1[13:7] ctrl_x2[20:14]            -
//                ctrl_y2[27:21] entry_index[34:28], zero to 40 bits
// m_axis    out  eased_value[16:0], zero to 24 bits                    is_linear
//
// one beat at a time: the last entry and linear curves skip the solver,
// a solved curve runs newton steps (a 16-bit restoring divide dominates
// each), bisection passes and then the y evaluation, rounding and output
// all polynomial work runs through one registered 48x18 multiply-add
// synchronous active-low reset clears the sequencer and the output valid
// tready is high only while idle; a result held by a stalled sink does not
// block the next beat from being taken
module bezier_easing_table_entry
    import bez_pkg::*;
#(
    parameter int TABLE_SIZE   = DEF_TABLE_SIZE,
    parameter int NEWTON_STEPS = DEF_NEWTON_STEPS,
    parameter int BISECT_STEPS = DEF_BISECT_STEPS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // ctrl_x1, ctrl_y1, ctrl_x2, ctrl_y2, entry_index, zero pad
    input  logic [39:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // eased_value, zero pad
    output logic [23:0] o_m_axis_tdata,
    // is_linear
    output logic        o_m_axis_tuser
);

    localparam int NI_W = $clog2(NEWTON_STEPS + 1);
    localparam int BI_W = $clog2(BISECT_STEPS + 1);
    localparam logic signed [ACC_W-1:0] TOL =
        ACC_W'(TOL_Q32) * ACC_W'(SCALE) * ACC_W'(TABLE_SIZE);
    localparam logic signed [ACC_W-1:0] SLOPE_MIN = ACC_W'(SLOPE_MIN_Q32 * SCALE);

    t_state r_state, n_state;

    logic [CTRL_W-1:0] w_x1, w_y1, w_x2, w_y2, w_idx;
    logic [COEF_W-1:0] r_xa, r_xb, r_xc, r_ya, r_yb, r_yc;
    logic [ACC_W-1:0]  r_goal;
    logic [T_W-1:0]    r_start, r_t, r_lo, r_hi;
    logic [NI_W-1:0]   r_i;
    logic [BI_W-1:0]   r_j;
    logic              r_bisect, r_eneg, r_lin;
    logic [ACC_W-1:0]  r_mag, r_rem, r_den;
    logic [QUO_W-1:0]  r_quo, r_num;
    logic [CNT_W-1:0]  r_cnt;
    logic [VAL_W-1:0]  r_val;
    logic              r_ovalid;
    logic [VAL_W-1:0]  r_oval;
    logic              r_olin;

    t_mac_op                 w_op;
    logic signed [ACC_W-1:0] w_acc;
    logic [ACC_W-1:0]        w_abs, w_rs, w_yr;
    logic                    w_tol_hit, w_last, w_lin, w_take, w_load;
    logic signed [T_W+2:0]   w_tn;
    logic [COEF_W:0]         w_a3, w_b2;
    logic [QUO_W-1:0]        w_yq;

    // start point and linear value for every index, constant per table size
    logic [T_W-1:0]   w_start_lut [0:(1 << CTRL_W)-1];
    logic [VAL_W-1:0] w_lin_lut   [0:(1 << CTRL_W)-1];

    for (genvar g = 0; g < (1 << CTRL_W); g++) begin : g_lut
        assign w_start_lut[g] = T_W'((g * ONE_Q16) / TABLE_SIZE);
        assign w_lin_lut[g]   = VAL_W'((g * ONE_Q16 + TABLE_SIZE / 2) / TABLE_SIZE);
    end

    assign w_x1  = i_s_axis_tdata[6:0];
    assign w_y1  = i_s_axis_tdata[13:7];
    assign w_x2  = i_s_axis_tdata[20:14];
    assign w_y2  = i_s_axis_tdata[27:21];
    assign w_idx = i_s_axis_tdata[34:28];

    assign w_take = i_s_axis_tvalid && (r_state == ST_IDLE);
    assign w_last = 32'(w_idx) >= TABLE_SIZE;
    assign w_lin  = (w_x1 == w_y1) && (w_x2 == w_y2);
    assign w_load = (r_state == ST_DONE) && (!r_ovalid || i_m_axis_tready);

    bez_mac u_mac (
        .i_clk (i_clk),
        .i_op  (w_op),
        .o_acc (w_acc)
    );

    assign w_abs     = w_acc[ACC_W-1] ? (ACC_W'(0) - w_acc) : w_acc;
    assign w_tol_hit = $signed(w_abs) < TOL;
    assign w_rs      = {r_rem[ACC_W-2:0], r_num[QUO_W-1]};
    assign w_yr      = w_acc + (ACC_W'(SCALE) << 31);
    assign w_a3      = {r_xa[COEF_W-1], r_xa} + {r_xa, 1'b0};
    assign w_b2      = {r_xb, 1'b0};
    // x below the sample moves t up, as newton steps against the error sign
    assign w_tn = r_eneg ? ($signed({3'b0, r_t}) + $signed({2'b0, r_quo[T_W:0]}))
                         : ($signed({3'b0, r_t}) - $signed({2'b0, r_quo[T_W:0]}));
    // remainder is below 4 * 127, each threshold adds one to the estimate
    assign w_yq = r_quo + QUO_W'(r_rem >= ACC_W'(SCALE))
                        + QUO_W'(r_rem >= ACC_W'(2 * SCALE))
                        + QUO_W'(r_rem >= ACC_W'(3 * SCALE));

    // multiply-add operand selection
    always_comb begin
        w_op.en = 1'b0;
        w_op.a  = '0;
        w_op.b  = $signed({1'b0, r_t});
        w_op.c  = '0;
        unique case (r_state)
            ST_X1: begin
                w_op.en = 1'b1;
                w_op.a  = MAC_A_W'($signed(r_xa));
                w_op.c  = ACC_W'($signed(r_xb)) <<< 16;
            end
            ST_X2: begin
                w_op.en = 1'b1;
                w_op.a  = w_acc[MAC_A_W-1:0];
                w_op.c  = ACC_W'($signed(r_xc)) <<< 32;
            end
            ST_X3: begin
                w_op.en = 1'b1;
                w_op.a  = w_acc[MAC_A_W-1:0];
            end
            ST_XE: begin
                w_op.en = 1'b1;
                w_op.a  = w_acc[ACC_W-1:16];
                w_op.b  = MAC_B_W'(TABLE_SIZE);
                w_op.c  = ACC_W'(0) - r_goal;
            end
            ST_S1: begin
                w_op.en = 1'b1;
                w_op.a  = MAC_A_W'($signed(w_a3));
                w_op.c  = ACC_W'($signed(w_b2)) <<< 16;
            end
            ST_S2: begin
                w_op.en = 1'b1;
                w_op.a  = w_acc[MAC_A_W-1:0];
                w_op.c  = ACC_W'($signed(r_xc)) <<< 32;
            end
            ST_S3: begin
                w_op.en = 1'b1;
                w_op.a  = w_acc[MAC_A_W-1:0];
                w_op.b  = MAC_B_W'(TABLE_SIZE);
            end
            ST_Y1: begin
                w_op.en = 1'b1;
                w_op.a  = MAC_A_W'($signed(r_ya));
                w_op.c  = ACC_W'($signed(r_yb)) <<< 16;
            end
            ST_Y2: begin
                w_op.en = 1'b1;
                w_op.a  = w_acc[MAC_A_W-1:0];
                w_op.c  = ACC_W'($signed(r_yc)) <<< 32;
            end
            ST_Y3: begin
                w_op.en = 1'b1;
                w_op.a  = w_acc[MAC_A_W-1:0];
            end
            default: begin
                w_op.en = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    n_state = (w_last || w_lin) ? ST_DONE : ST_X1;
                end
            end
            ST_LOOP: begin
                if (!r_bisect) begin
                    n_state = (32'(r_i) >= NEWTON_STEPS) ? ST_LOOP : ST_X1;
                end else if ((32'(r_j) < BISECT_STEPS) && (r_lo < r_hi)) begin
                    n_state = ST_X1;
                end else begin
                    n_state = ST_Y1;
                end
            end
            ST_X1:  n_state = ST_X2;
            ST_X2:  n_state = ST_X3;
            ST_X3:  n_state = ST_XE;
            ST_XE:  n_state = ST_CHK;
            ST_CHK: begin
                if (w_tol_hit) begin
                    n_state = ST_Y1;
                end else begin
                    n_state = r_bisect ? ST_LOOP : ST_S1;
                end
            end
            ST_S1:  n_state = ST_S2;
            ST_S2:  n_state = ST_S3;
            ST_S3:  n_state = ($signed(w_acc) < SLOPE_MIN) ? ST_LOOP : ST_DS;
            ST_DS: begin
                n_state = (r_mag >= {w_acc[ACC_W-2:0], 1'b0}) ? ST_UPD : ST_DIV;
            end
            ST_DIV: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: n_state = ST_LOOP;
            ST_Y1:  n_state = ST_Y2;
            ST_Y2:  n_state = ST_Y3;
            ST_Y3:  n_state = ST_YR;
            ST_YR:  n_state = ($signed(w_acc) <= 0) ? ST_DONE : ST_YQ;
            ST_YQ:  n_state = ST_YC;
            ST_YC:  n_state = ST_YSAT;
            ST_YSAT: n_state = ST_DONE;
            ST_DONE: n_state = w_load ? ST_IDLE : ST_DONE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_oval <= r_val;
            r_olin <= r_lin;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_take) begin
                    r_xa     <= COEF_W'(SCALE) + COEF_W'(3) * COEF_W'(w_x1)
                                - COEF_W'(3) * COEF_W'(w_x2);
                    r_xb     <= COEF_W'(3) * COEF_W'(w_x2) - COEF_W'(6) * COEF_W'(w_x1);
                    r_xc     <= COEF_W'(3) * COEF_W'(w_x1);
                    r_ya     <= COEF_W'(SCALE) + COEF_W'(3) * COEF_W'(w_y1)
                                - COEF_W'(3) * COEF_W'(w_y2);
                    r_yb     <= COEF_W'(3) * COEF_W'(w_y2) - COEF_W'(6) * COEF_W'(w_y1);
                    r_yc     <= COEF_W'(3) * COEF_W'(w_y1);
                    r_goal   <= ACC_W'(14'(w_idx) * 14'(SCALE)) << 32;
                    r_start  <= w_start_lut[w_idx];
                    r_t      <= w_start_lut[w_idx];
                    r_i      <= '0;
                    r_bisect <= 1'b0;
                    r_lin    <= w_lin;
                    if (w_last) begin
                        r_val <= VAL_W'(ONE_Q16);
                    end else begin
                        r_val <= w_lin_lut[w_idx];
                    end
                end
            end
            ST_LOOP: begin
                if (!r_bisect && (32'(r_i) >= NEWTON_STEPS)) begin
                    r_bisect <= 1'b1;
                    r_t      <= r_start;
                    r_lo     <= '0;
                    r_hi     <= T_W'(ONE_Q16);
                    r_j      <= '0;
                end
            end
            ST_CHK: begin
                r_mag  <= w_abs;
                r_eneg <= w_acc[ACC_W-1];
            end
            ST_S3: begin
                // flat slope: give up on newton
                if ($signed(w_acc) < SLOPE_MIN) begin
                    r_bisect <= 1'b1;
                    r_t      <= r_start;
                    r_lo     <= '0;
                    r_hi     <= T_W'(ONE_Q16);
                    r_j      <= '0;
                end
            end
            ST_DS: begin
                r_den <= w_acc;
                r_num <= '0;
                r_cnt <= CNT_W'(NEWTON_BITS);
                if (r_mag >= {w_acc[ACC_W-2:0], 1'b0}) begin
                    r_quo <= QUO_W'(2 * ONE_Q16);
                end else if (r_mag >= w_acc) begin
                    r_quo <= QUO_W'(1);
                    r_rem <= r_mag - w_acc;
                end else begin
                    r_quo <= '0;
                    r_rem <= r_mag;
                end
            end
            ST_DIV: begin
                r_num <= {r_num[QUO_W-2:0], 1'b0};
                r_cnt <= r_cnt - CNT_W'(1);
                if (w_rs >= r_den) begin
                    r_rem <= w_rs - r_den;
                    r_quo <= {r_quo[QUO_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_rs;
                    r_quo <= {r_quo[QUO_W-2:0], 1'b0};
                end
            end
            ST_UPD: begin
                r_i <= r_i + NI_W'(1);
                if (w_tn < 0) begin
                    r_t <= '0;
                end else if (w_tn > ONE_Q16) begin
                    r_t <= T_W'(ONE_Q16);
                end else begin
                    r_t <= w_tn[T_W-1:0];
                end
            end
            ST_YR: begin
                r_val <= '0;
                r_num <= w_yr[QUO_W+31:32];
            end
            ST_YQ: begin
                // 127 = 2^7 - 1: the shifted sum undershoots n / 127 by at most 3
                r_quo <= QUO_W'(r_num >> 7) + QUO_W'(r_num >> 14) + QUO_W'(r_num >> 21);
            end
            ST_YC: begin
                r_rem <= ACC_W'(r_num) - ((ACC_W'(r_quo) << 7) - ACC_W'(r_quo));
            end
            ST_YSAT: begin
                r_val <= (w_yq > QUO_W'(ONE_Q16)) ? VAL_W'(ONE_Q16) : w_yq[VAL_W-1:0];
            end
            default: begin
            end
        endcase
        // bisection bound update follows the error sign of this pass
        if ((r_state == ST_CHK) && r_bisect && !w_tol_hit) begin
            r_lo <= w_acc[ACC_W-1] ? r_t : r_lo;
            r_hi <= w_acc[ACC_W-1] ? r_hi : r_t;
            r_t  <= (w_acc[ACC_W-1] ? r_t : r_lo)
                    + (((w_acc[ACC_W-1] ? r_hi : r_t)
                       - (w_acc[ACC_W-1] ? r_t : r_lo)) >> 1);
            r_j  <= r_j + BI_W'(1);
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {7'b0, r_oval};
    assign o_m_axis_tuser  = r_olin;

endmodule

// ----- bench/bezier_easing_table_entry_tb.sv -----
module bezier_easing_table_entry_tb
    import bez_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TSIZE   = DEF_TABLE_SIZE;
    localparam int NSTEPS  = DEF_NEWTON_STEPS;
    localparam int BSTEPS  = DEF_BISECT_STEPS;
    localparam int N_RAND  = 1900;
    localparam int MAX_ERR = 10;

    // first field in the lowest bits, as on the bus
    typedef struct packed {
        logic [6:0] idx;
        logic [6:0] y2;
        logic [6:0] x2;
        logic [6:0] y1;
        logic [6:0] x1;
    } curve_req_t;

    typedef struct packed {
        logic [16:0] value;
        logic        linear;
    } eased_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    // ctrl_x1, ctrl_y1, ctrl_x2, ctrl_y2, entry_index, zero pad
    logic [39:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    // eased_value, zero pad
    logic [23:0] o_m_axis_tdata;
    // is_linear
    logic        o_m_axis_tuser;

    curve_req_t req_queue[$];
    eased_t     expected_values[$];
    int         mismatches;
    int         send_gap;
    int         recv_gap;
    int         hold_cycles;

    bezier_easing_table_entry uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    function automatic longint floor_q16(longint v);
        if (v >= 0) return v >>> 16;
        return -((-v + 65535) >>> 16);
    endfunction

    function automatic longint poly_value(longint a, longint b, longint c, longint t);
        return a * t * t * t + b * t * t * 65536 + c * t * 64'sd4294967296;
    endfunction

    function automatic longint poly_slope(longint a, longint b, longint c, longint t);
        return 3 * a * t * t + 2 * b * t * 65536 + c * 64'sd4294967296;
    endfunction

    function automatic longint find_param(longint cx1, longint cx2, longint idx);
        longint a, b, c, goal, tol, start, t, lo, hi, e, d, step;
        longint unsigned mag, den, q, r;
        a = 127 + 3 * cx1 - 3 * cx2;
        b = 3 * cx2 - 6 * cx1;
        c = 3 * cx1;
        goal = 127 * idx * 64'sd4294967296;
        tol = longint'(TOL_Q32) * 127 * TSIZE;
        start = (idx * ONE_Q16) / TSIZE;
        t = start;
        lo = 0;
        hi = ONE_Q16;
        for (int i = 0; i < NSTEPS; i++) begin
            e = floor_q16(poly_value(a, b, c, t)) * TSIZE - goal;
            mag = (e < 0) ? -e : e;
            if (mag < tol) return t;
            d = poly_slope(a, b, c, t);
            if (d < longint'(SLOPE_MIN_Q32) * 127) break;
            den = longint'(d) * TSIZE;
            q = mag / den;
            r = mag % den;
            if (q >= 2) begin
                step = 2 * ONE_Q16;
            end else begin
                for (int k = 0; k < 16; k++) begin
                    r = r << 1;
                    q = q << 1;
                    if (r >= den) begin
                        r = r - den;
                        q = q | 1;
                    end
                end
                step = q;
            end
            t = (e > 0) ? t - step : t + step;
            if (t < 0) t = 0;
            if (t > ONE_Q16) t = ONE_Q16;
        end
        t = start;
        for (int i = 0; i < BSTEPS && lo < hi; i++) begin
            e = floor_q16(poly_value(a, b, c, t)) * TSIZE - goal;
            mag = (e < 0) ? -e : e;
            if (mag < tol) return t;
            if (e < 0) lo = t;
            else hi = t;
            t = lo + (hi - lo) / 2;
        end
        return t;
    endfunction

    function automatic eased_t ease_entry(curve_req_t rq);
        eased_t res;
        longint val, t, yv, unit;
        res.linear = (rq.x1 == rq.y1) && (rq.x2 == rq.y2);
        if (rq.idx >= TSIZE) begin
            val = ONE_Q16;
        end else if (res.linear) begin
            val = (longint'(rq.idx) * ONE_Q16 + TSIZE / 2) / TSIZE;
        end else begin
            t = find_param(rq.x1, rq.x2, rq.idx);
            yv = poly_value(127 + 3 * longint'(rq.y1) - 3 * longint'(rq.y2),
                            3 * longint'(rq.y2) - 6 * longint'(rq.y1),
                            3 * longint'(rq.y1), t);
            unit = 127 * 64'sd4294967296;
            if (yv <= 0) val = 0;
            else begin
                val = (yv + unit / 2) / unit;
                if (val > ONE_Q16) val = ONE_Q16;
            end
        end
        res.value = val[16:0];
        return res;
    endfunction

    function automatic curve_req_t make_req(int x1, int y1, int x2, int y2, int idx);
        curve_req_t rq;
        rq.x1 = 7'(x1);
        rq.y1 = 7'(y1);
        rq.x2 = 7'(x2);
        rq.y2 = 7'(y2);
        rq.idx = 7'(idx);
        return rq;
    endfunction

    function automatic curve_req_t random_req();
        curve_req_t rq;
        rq = make_req($urandom_range(0, 127), $urandom_range(0, 127),
                      $urandom_range(0, 127), $urandom_range(0, 127),
                      $urandom_range(0, 63));
        case ($urandom_range(0, 9))
            0: rq.idx = 7'($urandom_range(64, 127));
            1: begin
                rq.y1 = rq.x1;
                rq.y2 = rq.x2;
            end
            2: rq.idx = $urandom_range(0, 1) ? 7'd0 : 7'd63;
            3: begin
                // steep ends drive newton out of range
                rq.x1 = 7'($urandom_range(100, 127));
                rq.x2 = 7'($urandom_range(0, 20));
            end
            default: ;
        endcase
        return rq;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        req_queue.push_back(make_req(0, 0, 0, 0, 0));
        req_queue.push_back(make_req(127, 127, 127, 127, 127));
        req_queue.push_back(make_req(0, 0, 127, 127, 32));
        req_queue.push_back(make_req(10, 10, 90, 90, 17));
        req_queue.push_back(make_req(0, 127, 127, 0, 64));
        req_queue.push_back(make_req(0, 127, 127, 0, 63));
        req_queue.push_back(make_req(127, 0, 0, 127, 1));
        req_queue.push_back(make_req(127, 0, 0, 127, 32));
        req_queue.push_back(make_req(127, 127, 0, 0, 33));
        req_queue.push_back(make_req(0, 0, 127, 0, 40));
        req_queue.push_back(make_req(127, 127, 127, 0, 5));
        req_queue.push_back(make_req(0, 127, 0, 127, 60));
        req_queue.push_back(make_req(85, 42, 85, 0, 31));
        req_queue.push_back(make_req(42, 0, 74, 127, 0));
        req_queue.push_back(make_req(127, 127, 0, 127, 62));
        req_queue.push_back(make_req(1, 2, 126, 125, 100));
        req_queue.push_back(make_req(127, 0, 127, 127, 20));
        req_queue.push_back(make_req(0, 0, 0, 127, 48));
        for (int i = 0; i < N_RAND; i++) req_queue.push_back(random_req());
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (req_queue.size() == 0 && !i_s_axis_tvalid);
        wait (expected_values.size() == 0);
        repeat (500) @(posedge i_clk);
        if (mismatches == 0 && expected_values.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata <= '0;
            send_gap <= 0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (i_s_axis_tvalid)
                expected_values.push_back(ease_entry(curve_req_t'(i_s_axis_tdata[34:0])));
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_s_axis_tvalid <= 1'b0;
            end else if (req_queue.size() > 0) begin
                i_s_axis_tdata <= {5'd0, req_queue.pop_front()};
                i_s_axis_tvalid <= 1'b1;
                send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long sink hold-off once the block has work in flight
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cycles <= 3000;
        end else if (hold_cycles > 0 && expected_values.size() > 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // monitor and sink stall
    always @(posedge i_clk) begin
        eased_t got, want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            recv_gap <= 0;
            mismatches <= 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.value = o_m_axis_tdata[16:0];
                got.linear = o_m_axis_tuser;
                if (expected_values.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < MAX_ERR)
                        $display("unexpected beat value=%0d linear=%0b", got.value, got.linear);
                end else begin
                    want = expected_values.pop_front();
                    if (got !== want || o_m_axis_tdata[23:17] !== '0) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < MAX_ERR)
                            $display("mismatch value exp=%0d got=%0d linear exp=%0b got=%0b",
                                     want.value, got.value, want.linear, got.linear);
                    end
                end
            end
            if (hold_cycles > 0 && expected_values.size() > 0) begin
                i_m_axis_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
                if (o_m_axis_tvalid)
                    recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            end
        end
    end

endmodule
